@@ rtl/u2c_pkg.sv @@
// u2c_pkg: shared constants, types and the month table for the unix time to calendar block
// used by every module in rtl; depends on nothing

package u2c_pkg;

    // day count from secs: (secs >> 7) / 675 by reciprocal
    localparam logic [25:0] DAY_RECIP      = 26'd50903317;
    localparam int          DAY_SHIFT      = 35;
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;

    // march-based day count from 1968-03-01
    localparam logic [15:0] EPOCH_OFFSET   = 16'd671;
    // 2100-03-01 on that count; 2100 has no leap day
    localparam logic [15:0] CENTURY_GAP    = 16'd48212;

    // hour: (tod >> 4) / 225 by reciprocal
    localparam logic [13:0] HOUR_RECIP     = 14'd9321;
    localparam int          HOUR_SHIFT     = 21;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;

    // four-year cycle: z / 1461 by reciprocal
    localparam logic [16:0] QUAD_RECIP     = 17'd91868;
    localparam int          QUAD_SHIFT     = 27;
    localparam logic [10:0] DAYS_PER_QUAD  = 11'd1461;
    localparam logic [10:0] DAYS_PER_YEAR  = 11'd365;
    localparam logic [10:0] DAYS_TWO_YEARS = 11'd730;
    localparam logic [10:0] DAYS_THREE_YRS = 11'd1095;
    localparam logic [11:0] BASE_YEAR      = 12'd1968;

    // minute: (rem >> 2) / 15 by reciprocal
    localparam logic [10:0] MIN_RECIP      = 11'd1093;
    localparam int          MIN_SHIFT      = 14;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;

    // march-based month index to calendar month
    localparam logic [3:0]  MONTHS_IN_YEAR = 4'd12;
    localparam logic [3:0]  JANUARY_INDEX  = 4'd10;
    localparam logic [3:0]  MONTH_FROM_MAR = 4'd3;
    localparam logic [3:0]  MONTH_WRAP     = 4'd9;

    typedef struct packed {
        logic        valid;
        logic [16:0] tod;
        logic [15:0] zday;
    } u2c_split_t;

    // first day of each month within a march-based year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

@@ rtl/u2c_day_split.sv @@
// u2c_day_split: stages 1 and 2, splits seconds into whole days and time of day
// depends on u2c_pkg

module u2c_day_split (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [31:0]         unix_seconds,
    output u2c_pkg::u2c_split_t split
);
    import u2c_pkg::*;

    logic        s1_valid_reg;
    logic [16:0] s1_secs_reg;
    logic [15:0] s1_days_reg;
    logic        s2_valid_reg;
    logic [16:0] s2_tod_reg;
    logic [15:0] s2_zday_reg;

    logic [50:0] day_prod;
    logic [15:0] s1_days_next;
    logic [32:0] tod_prod;
    logic [16:0] s2_tod_next;
    logic [15:0] zbase;
    logic [15:0] s2_zday_next;

    assign day_prod     = unix_seconds[31:7] * DAY_RECIP;
    assign s1_days_next = day_prod[DAY_SHIFT+15:DAY_SHIFT];

    assign tod_prod     = s1_days_reg * SECS_PER_DAY;
    assign s2_tod_next  = s1_secs_reg - tod_prod[16:0];
    assign zbase        = s1_days_reg + EPOCH_OFFSET;
    // skip the missing leap day of 2100
    assign s2_zday_next = zbase + {15'd0, zbase >= CENTURY_GAP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_secs_reg <= unix_seconds[16:0];
        s1_days_reg <= s1_days_next;
        s2_tod_reg  <= s2_tod_next;
        s2_zday_reg <= s2_zday_next;
    end

    assign split.valid = s2_valid_reg;
    assign split.tod   = s2_tod_reg;
    assign split.zday  = s2_zday_reg;

endmodule

@@ rtl/u2c_clock.sv @@
// u2c_clock: stages 3 to 6, hour, minute and second from the time of day
// depends on u2c_pkg

module u2c_clock (
    input  logic        clk,
    input  logic [16:0] tod,
    output logic [4:0]  hour_of_day,
    output logic [5:0]  minute_of_hour,
    output logic [5:0]  second_of_minute
);
    import u2c_pkg::*;

    logic [4:0]  s3_hour_reg;
    logic [11:0] s3_tod_reg;
    logic [4:0]  s4_hour_reg;
    logic [11:0] s4_rem_reg;
    logic [4:0]  s5_hour_reg;
    logic [5:0]  s5_min_reg;
    logic [5:0]  s5_rem_reg;
    logic [4:0]  s6_hour_reg;
    logic [5:0]  s6_min_reg;
    logic [5:0]  s6_sec_reg;

    logic [26:0] hour_prod;
    logic [16:0] hour_secs;
    logic [11:0] s4_rem_next;
    logic [20:0] min_prod;
    logic [11:0] min_secs;
    logic [5:0]  s6_sec_next;

    assign hour_prod   = tod[16:4] * HOUR_RECIP;
    assign hour_secs   = s3_hour_reg * SECS_PER_HOUR;
    assign s4_rem_next = s3_tod_reg - hour_secs[11:0];
    assign min_prod    = s4_rem_reg[11:2] * MIN_RECIP;
    assign min_secs    = s5_min_reg * SECS_PER_MIN;
    assign s6_sec_next = s5_rem_reg - min_secs[5:0];

    always_ff @(posedge clk)
    begin
        s3_hour_reg <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
        s3_tod_reg  <= tod[11:0];
        s4_hour_reg <= s3_hour_reg;
        s4_rem_reg  <= s4_rem_next;
        s5_hour_reg <= s4_hour_reg;
        s5_min_reg  <= min_prod[MIN_SHIFT+5:MIN_SHIFT];
        s5_rem_reg  <= s4_rem_reg[5:0];
        s6_hour_reg <= s5_hour_reg;
        s6_min_reg  <= s5_min_reg;
        s6_sec_reg  <= s6_sec_next;
    end

    assign hour_of_day      = s6_hour_reg;
    assign minute_of_hour   = s6_min_reg;
    assign second_of_minute = s6_sec_reg;

endmodule

@@ rtl/u2c_date.sv @@
// u2c_date: stages 3 to 6, year, month and day from the march-based day count
// depends on u2c_pkg

module u2c_date (
    input  logic        clk,
    input  logic [15:0] zday,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_number,
    output logic [11:0] year_number
);
    import u2c_pkg::*;

    logic [5:0]  s3_quad_reg;
    logic [15:0] s3_zday_reg;
    logic [5:0]  s4_quad_reg;
    logic [10:0] s4_rday_reg;
    logic [8:0]  s5_doy_reg;
    logic [11:0] s5_year_reg;
    logic [4:0]  s6_day_reg;
    logic [3:0]  s6_month_reg;
    logic [11:0] s6_year_reg;

    logic [32:0] quad_prod;
    logic [16:0] quad_days;
    logic [10:0] s4_rday_next;
    logic [1:0]  yoe;
    logic [10:0] yoe_days;
    logic [8:0]  s5_doy_next;
    logic [11:0] s5_year_next;
    logic [3:0]  mp;
    logic [8:0]  day_full;
    logic [4:0]  s6_day_next;
    logic [3:0]  s6_month_next;
    logic [11:0] s6_year_next;

    assign quad_prod    = zday * QUAD_RECIP;
    assign quad_days    = s3_quad_reg * DAYS_PER_QUAD;
    assign s4_rday_next = s3_zday_reg[10:0] - quad_days[10:0];

    always_comb
    begin
        yoe = 2'd0;
        if (s4_rday_reg >= DAYS_PER_YEAR)
            yoe = 2'd1;
        if (s4_rday_reg >= DAYS_TWO_YEARS)
            yoe = 2'd2;
        if (s4_rday_reg >= DAYS_THREE_YRS)
            yoe = 2'd3;
    end

    assign yoe_days     = {9'd0, yoe} * DAYS_PER_YEAR;
    assign s5_doy_next  = s4_rday_reg[8:0] - yoe_days[8:0];
    assign s5_year_next = BASE_YEAR + {4'd0, s4_quad_reg, 2'b00} + {10'd0, yoe};

    always_comb
    begin
        mp = 4'd0;
        for (int i = 1; i < int'(MONTHS_IN_YEAR); i++)
        begin
            if (s5_doy_reg >= month_start(4'(i)))
                mp = mp + 4'd1;
        end
    end

    assign day_full      = s5_doy_reg - month_start(mp) + 9'd1;
    assign s6_day_next   = day_full[4:0];
    // january and february belong to the next calendar year
    assign s6_month_next = (mp >= JANUARY_INDEX) ? (mp - MONTH_WRAP) : (mp + MONTH_FROM_MAR);
    assign s6_year_next  = s5_year_reg + {11'd0, mp >= JANUARY_INDEX};

    always_ff @(posedge clk)
    begin
        s3_quad_reg  <= quad_prod[QUAD_SHIFT+5:QUAD_SHIFT];
        s3_zday_reg  <= zday;
        s4_quad_reg  <= s3_quad_reg;
        s4_rday_reg  <= s4_rday_next;
        s5_doy_reg   <= s5_doy_next;
        s5_year_reg  <= s5_year_next;
        s6_day_reg   <= s6_day_next;
        s6_month_reg <= s6_month_next;
        s6_year_reg  <= s6_year_next;
    end

    assign day_of_month = s6_day_reg;
    assign month_number = s6_month_reg;
    assign year_number  = s6_year_reg;

endmodule

@@ rtl/unix_time_to_calendar.sv @@
// unix_time_to_calendar: top level, converts unix seconds to a utc calendar date and time
// depends on u2c_pkg, u2c_day_split, u2c_clock, u2c_date
//
// a request is taken at a rising edge where start is high and busy is low;
// busy stays low, so a new request may be given in every cycle
// each request carries unix_seconds, an unsigned 32-bit count since 1970-01-01
// results come out in request order: done is high for exactly one cycle and
// day_of_month, month_number, year_number, hour_of_day, minute_of_hour and
// second_of_minute hold the result during that cycle
// done travels with the request through the valid bits of every stage
// throughput is one request per cycle, set by the six-stage pipeline: one
// constant-reciprocal multiply or one multiply-subtract per stage
// the receiver cannot stall, so no backpressure path exists
// rst_n clears the valid bits of every stage; requests in flight are dropped
// and done stays low until new requests come through

module unix_time_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] unix_seconds,
    output logic        done,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_number,
    output logic [11:0] year_number,
    output logic [4:0]  hour_of_day,
    output logic [5:0]  minute_of_hour,
    output logic [5:0]  second_of_minute
);
    import u2c_pkg::*;

    u2c_split_t  split;
    logic [3:0]  valid_reg;
    logic [3:0]  valid_next;

    assign busy = 1'b0;

    u2c_day_split u_split (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start & ~busy),
        .unix_seconds (unix_seconds),
        .split        (split)
    );

    u2c_clock u_clock (
        .clk              (clk),
        .tod              (split.tod),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

    u2c_date u_date (
        .clk          (clk),
        .zday         (split.zday),
        .day_of_month (day_of_month),
        .month_number (month_number),
        .year_number  (year_number)
    );

    // valid bits of stages 3 to 6
    assign valid_next = {valid_reg[2:0], split.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 4'd0;
        else
            valid_reg <= valid_next;
    end

    assign done = valid_reg[3];

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for unix_time_to_calendar, directed table then random requests
// holds its own calendar predictor and a queue of expected dates; needs only the rtl

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    typedef struct packed {
        logic [31:0] secs;
        logic        known;
        cal_t        want;
    } dir_row_t;

    localparam int NUM_DIR    = 16;
    localparam int NUM_RANDOM = 1035;
    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // rows with known set carry a hand-typed date, the rest go through the predictor
    localparam dir_row_t DIR_TABLE [NUM_DIR] = '{
        '{32'd0,          1'b1, '{5'd1,  4'd1,  12'd1970, 5'd0,  6'd0,  6'd0}},
        '{32'd86399,      1'b1, '{5'd1,  4'd1,  12'd1970, 5'd23, 6'd59, 6'd59}},
        '{32'd2678400,    1'b1, '{5'd1,  4'd2,  12'd1970, 5'd0,  6'd0,  6'd0}},
        '{32'd68169600,   1'b0, '0},
        '{32'd94694399,   1'b0, '0},
        '{32'd94694400,   1'b0, '0},
        '{32'd951782400,  1'b0, '0},
        '{32'd978220800,  1'b0, '0},
        '{32'd978307199,  1'b0, '0},
        '{32'd4107542399, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},
        '{32'd2147483647, 1'b1, '{5'd19, 4'd1,  12'd2038, 5'd3,  6'd14, 6'd7}},
        '{32'd2147483648, 1'b0, '0},
        '{32'hAAAAAAAA,   1'b0, '0},
        '{32'h55555555,   1'b0, '0},
        '{32'hFFFFFFFF,   1'b1, '{5'd7,  4'd2,  12'd2106, 5'd6,  6'd28, 6'd15}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] unix_seconds = '0;
    logic        busy;
    logic        done;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_number;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;

    // travels with the request so the monitor knows which expectation to queue
    logic        req_known = 1'b0;
    cal_t        req_want = '0;

    cal_t        pending_dates[$];
    int          errors = 0;
    int          burst_left = 0;

    unix_time_to_calendar dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .unix_seconds     (unix_seconds),
        .done             (done),
        .day_of_month     (day_of_month),
        .month_number     (month_number),
        .year_number      (year_number),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic cal_t calendar_of(logic [31:0] secs);
        cal_t        c;
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mo;
        int unsigned mlen;
        days = secs / 86400;
        tod  = secs % 86400;
        yr   = 1970;
        mo   = 0;
        while (days >= (leap_year(yr) ? 366 : 365))
        begin
            days -= leap_year(yr) ? 366 : 365;
            yr++;
        end
        while (mo < 11)
        begin
            mlen = (mo == 1 && leap_year(yr)) ? 29 : MONTH_DAYS[mo];
            if (days < mlen)
                break;
            days -= mlen;
            mo++;
        end
        c.day    = 5'(days + 1);
        c.month  = 4'(mo + 1);
        c.year   = 12'(yr);
        c.hour   = 5'(tod / 3600);
        c.minute = 6'((tod % 3600) / 60);
        c.second = 6'(tod % 60);
        return c;
    endfunction

    // random seconds, weighted toward day, month and year edges
    function automatic logic [31:0] pick_seconds();
        logic [63:0] s;
        logic [63:0] days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mo;
        case ($urandom_range(0, 4))
            0: tod = 0;
            1: tod = 86399;
            2: tod = 3599 + $urandom_range(0, 1);
            default: tod = $urandom_range(0, 86399);
        endcase
        case ($urandom_range(0, 5))
            0, 1:
                s = 64'($urandom);
            2:
                s = 64'hFFFF_FFFF - $urandom_range(0, 86400 * 60);
            3:
            begin
                days = $urandom_range(0, 49710);
                s = days * 86400 + tod;
            end
            default:
            begin
                yr = $urandom_range(1970, 2106);
                mo = $urandom_range(0, 11);
                days = 0;
                for (int unsigned y = 1970; y < yr; y++)
                    days += leap_year(y) ? 366 : 365;
                for (int unsigned m = 0; m < mo; m++)
                    days += (m == 1 && leap_year(yr)) ? 29 : MONTH_DAYS[m];
                // land on the first day of the month or the last day before it
                s = days * 86400 + tod - ($urandom_range(0, 1) * 86400);
            end
        endcase
        return s[31:0];
    endfunction

    task automatic send(logic [31:0] secs, logic known, cal_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start        <= 1'b1;
        unix_seconds <= secs;
        req_known    <= known;
        req_want     <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // request capture and result check
    always @(posedge clk)
    begin
        cal_t want;
        if (rst_n && start && !busy)
            pending_dates.insert(pending_dates.size(),
                                 req_known ? req_want : calendar_of(unix_seconds));
        if (rst_n && done)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
            end
            else
            begin
                want = pending_dates.pop_front();
                if (day_of_month !== want.day)
                begin
                    $error("day_of_month expected %0d got %0d", want.day, day_of_month);
                    errors++;
                end
                if (month_number !== want.month)
                begin
                    $error("month_number expected %0d got %0d", want.month, month_number);
                    errors++;
                end
                if (year_number !== want.year)
                begin
                    $error("year_number expected %0d got %0d", want.year, year_number);
                    errors++;
                end
                if (hour_of_day !== want.hour)
                begin
                    $error("hour_of_day expected %0d got %0d", want.hour, hour_of_day);
                    errors++;
                end
                if (minute_of_hour !== want.minute)
                begin
                    $error("minute_of_hour expected %0d got %0d", want.minute, minute_of_hour);
                    errors++;
                end
                if (second_of_minute !== want.second)
                begin
                    $error("second_of_minute expected %0d got %0d",
                           want.second, second_of_minute);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < NUM_DIR; i++)
            send(DIR_TABLE[i].secs, DIR_TABLE[i].known, DIR_TABLE[i].want);
        for (int i = 0; i < NUM_RANDOM; i++)
            send(pick_seconds(), 1'b0, '0);
        start <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

endmodule
